>>> src/swr_pkg.sv
package swr_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 64;
  localparam int CNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int DEF_MAX_WORD_BYTES = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_WORD = 2'd0,
    REG_MATCH_LEN  = 2'd1,
    REG_REPL_WORD  = 2'd2,
    REG_REPL_LEN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_done;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] matched_count;
    logic             word_mismatched;
  } state_t;

  // one run of results: word bytes, then an optional copy of the input byte
  typedef struct packed {
    logic              src_repl;
    logic [CNT_W-1:0]  word_cnt;
    logic              has_tail;
    logic [BYTE_W-1:0] tail_byte;
    logic              eos;
  } run_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

>>> src/swr_run_gen.sv
module swr_run_gen #(
  parameter int MAX_WORD_BYTES = swr_pkg::DEF_MAX_WORD_BYTES
) (
  input  swr_pkg::in_t                      item,
  input  swr_pkg::state_t                   state,
  input  logic [swr_pkg::WORD_W-1:0]        match_word,
  input  logic [swr_pkg::CNT_W-1:0]         match_len,
  input  logic [swr_pkg::CNT_W-1:0]         repl_len,
  output swr_pkg::run_t                     run,
  output swr_pkg::state_t                   state_nxt
);

  localparam logic [swr_pkg::CNT_W-1:0] MaxCnt = swr_pkg::CNT_W'(MAX_WORD_BYTES);

  logic [swr_pkg::CNT_W-1:0]  eff_match_len;
  logic [swr_pkg::CNT_W-1:0]  eff_repl_len;
  logic [swr_pkg::BYTE_W-1:0] expect_byte;
  logic [swr_pkg::CNT_W-1:0]  cnt_inc;
  logic                       hit;

  always_comb begin
    if (match_len == '0) begin
      eff_match_len = swr_pkg::CNT_W'(1);
    end else if (match_len > MaxCnt) begin
      eff_match_len = MaxCnt;
    end else begin
      eff_match_len = match_len;
    end
    eff_repl_len = (repl_len > MaxCnt) ? MaxCnt : repl_len;
  end

  assign expect_byte = match_word[8*state.matched_count[2:0] +: swr_pkg::BYTE_W];
  assign cnt_inc = state.matched_count + swr_pkg::CNT_W'(1);
  assign hit = (state.matched_count < eff_match_len) && (item.in_byte == expect_byte);

  always_comb begin
    run.src_repl = 1'b0;
    run.word_cnt = '0;
    run.has_tail = 1'b1;
    run.tail_byte = item.in_byte;
    run.eos = item.end_of_stream;
    state_nxt = state;
    if (swr_pkg::is_space(item.in_byte)) begin
      if (!state.word_mismatched && (state.matched_count != '0)) begin
        if (state.matched_count == eff_match_len) begin
          run.src_repl = 1'b1;
          run.word_cnt = eff_repl_len;
        end else begin
          run.word_cnt = state.matched_count;
        end
      end
      state_nxt = '0;
    end else if (state.word_mismatched) begin
      run.has_tail = 1'b1;
    end else if (hit) begin
      run.has_tail = 1'b0;
      state_nxt.matched_count = cnt_inc;
      // end of stream closes the word that is still held
      if (item.end_of_stream) begin
        if (cnt_inc == eff_match_len) begin
          run.src_repl = 1'b1;
          run.word_cnt = eff_repl_len;
        end else begin
          run.word_cnt = cnt_inc;
        end
      end
    end else begin
      run.word_cnt = state.matched_count;
      state_nxt.matched_count = '0;
      state_nxt.word_mismatched = 1'b1;
    end
    if (item.end_of_stream) begin
      state_nxt = '0;
    end
  end

endmodule

>>> src/stream_word_replace_unit.sv
// channel  ports                                  payload
// input    in_valid / in_ready / in_data          swr_pkg::in_t
// result   out_valid / out_ready / out_data       swr_pkg::out_t
// config   cfg_valid / cfg_ready / cfg_index,     64-bit data, always ready
//          cfg_data
// an item gives 0 to 9 result bytes (up to 8 word bytes, then a tail byte),
// held in the run register, which feeds the output register one byte per
// cycle when not stalled, so single-result items also flow at one per cycle.
// rst_n clears word state, run and output valid; config returns to defaults.
// a stalled output holds the run register, which holds off in_ready.
module stream_word_replace_unit #(
  parameter int MAX_WORD_BYTES = swr_pkg::DEF_MAX_WORD_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  swr_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output swr_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swr_pkg::WORD_W-1:0]       cfg_data
);

  logic [swr_pkg::WORD_W-1:0] match_word_r;
  logic [swr_pkg::CNT_W-1:0]  match_len_r;
  logic [swr_pkg::WORD_W-1:0] repl_word_r;
  logic [swr_pkg::CNT_W-1:0]  repl_len_r;

  swr_pkg::state_t state_r;
  swr_pkg::state_t state_nxt;
  swr_pkg::run_t   run_new;
  swr_pkg::run_t   run_r;
  logic            run_valid_r;
  logic [swr_pkg::CNT_W-1:0] run_pos_r;
  logic [swr_pkg::CNT_W-1:0] run_total_r;
  logic [swr_pkg::CNT_W-1:0] new_total;

  logic            out_valid_r;
  swr_pkg::out_t   out_data_r;
  swr_pkg::out_t   out_data_nxt;
  logic            out_load;
  logic            run_last;
  logic            in_fire;
  logic [swr_pkg::WORD_W-1:0] src_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_word_r <= '0;
      match_len_r <= swr_pkg::CNT_W'(1);
      repl_word_r <= '0;
      repl_len_r <= '0;
    end else if (cfg_valid) begin
      case (swr_pkg::cfg_reg_t'(cfg_index))
        swr_pkg::REG_MATCH_WORD: match_word_r <= cfg_data;
        swr_pkg::REG_MATCH_LEN:  match_len_r <= cfg_data[swr_pkg::CNT_W-1:0];
        swr_pkg::REG_REPL_WORD:  repl_word_r <= cfg_data;
        swr_pkg::REG_REPL_LEN:   repl_len_r <= cfg_data[swr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  swr_run_gen #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_run_gen (
    .item       (in_data),
    .state      (state_r),
    .match_word (match_word_r),
    .match_len  (match_len_r),
    .repl_len   (repl_len_r),
    .run        (run_new),
    .state_nxt  (state_nxt)
  );

  assign new_total = run_new.word_cnt + swr_pkg::CNT_W'(run_new.has_tail);

  assign out_load = run_valid_r && (!out_valid_r || out_ready);
  assign run_last = (run_pos_r == run_total_r - swr_pkg::CNT_W'(1));
  assign in_ready = !run_valid_r || (out_load && run_last);
  assign in_fire = in_valid && in_ready;

  assign src_word = run_r.src_repl ? repl_word_r : match_word_r;

  always_comb begin
    if (run_pos_r < run_r.word_cnt) begin
      out_data_nxt.out_byte = src_word[8*run_pos_r[2:0] +: swr_pkg::BYTE_W];
    end else begin
      out_data_nxt.out_byte = run_r.tail_byte;
    end
    out_data_nxt.last_of_run = run_last;
    out_data_nxt.stream_done = run_last && run_r.eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      run_valid_r <= 1'b0;
      run_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        run_valid_r <= (new_total != '0);
        run_pos_r <= '0;
      end else if (out_load) begin
        run_pos_r <= run_pos_r + swr_pkg::CNT_W'(1);
        if (run_last) begin
          run_valid_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      run_r <= run_new;
      run_total_r <= new_total;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !run_valid_r |-> in_ready)
    else $error("input stalled with no run pending");

  a_run_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_total_r != '0) && (run_pos_r < run_total_r))
    else $error("run position out of range");

  a_mismatch_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.word_mismatched |-> (state_r.matched_count == '0))
    else $error("mismatched word kept a match count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.matched_count <= swr_pkg::CNT_W'(MAX_WORD_BYTES))
    else $error("match count beyond word size");

endmodule
